/* rtl/hrlp_pkg.sv */
package hrlp_pkg;

    localparam int DEFAULT_MAX_LINE = 4096;
    localparam int POS_W = 12;
    localparam int VER_W = 10;

    typedef enum logic [1:0] {
        STATUS_CONT        = 2'd0,
        STATUS_OK          = 2'd1,
        STATUS_BAD_METHOD  = 2'd2,
        STATUS_BAD_REQUEST = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        METHOD_UNKNOWN = 2'd0,
        METHOD_GET     = 2'd1,
        METHOD_HEAD    = 2'd2,
        METHOD_POST    = 2'd3
    } method_t;

    typedef struct packed {
        status_t            status;
        method_t            method_code;
        logic [VER_W-1:0]   version_major;
        logic [VER_W-1:0]   version_minor;
        logic [POS_W-1:0]   line_start_offset;
        logic [POS_W-1:0]   method_end_offset;
        logic [POS_W-1:0]   uri_start_offset;
        logic [POS_W-1:0]   uri_end_offset;
        logic [POS_W-1:0]   line_end_offset;
    } result_t;

endpackage

/* rtl/hrlp_core.sv */
module hrlp_core #(
    parameter int MAX_LINE = hrlp_pkg::DEFAULT_MAX_LINE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    output hrlp_pkg::result_t result
);

    localparam int POS_W = hrlp_pkg::POS_W;
    localparam int VER_W = hrlp_pkg::VER_W;
    localparam int LIMIT_INT = (MAX_LINE - 1 > 4095) ? 4095 : MAX_LINE - 1;
    localparam logic [POS_W-1:0] PosLimit = POS_W'(LIMIT_INT);
    localparam logic [VER_W-1:0] VerMax = VER_W'(999);

    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChSp    = 8'h20;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChH     = 8'h48;
    localparam logic [7:0] ChT     = 8'h54;
    localparam logic [7:0] ChP     = 8'h50;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChOne   = 8'h31;
    localparam logic [7:0] ChNine  = 8'h39;

    typedef enum logic [3:0] {
        ST_START, ST_METHOD, ST_PRE_URI, ST_URI, ST_PRE_PROTO, ST_H, ST_HT,
        ST_HTT, ST_HTTP, ST_MAJ_FIRST, ST_MAJ, ST_MIN_FIRST, ST_MIN, ST_TRAIL, ST_CR
    } state_t;

    state_t                 state_reg, state_next;
    logic [31:0]            mbytes_reg, mbytes_next;
    logic [2:0]             mlen_reg, mlen_next;
    logic [VER_W-1:0]       major_reg, major_next;
    logic [VER_W-1:0]       minor_reg, minor_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       start_reg, start_next;
    logic [POS_W-1:0]       mend_reg, mend_next;
    logic [POS_W-1:0]       ustart_reg, ustart_next;
    logic [POS_W-1:0]       uend_reg, uend_next;
    logic [POS_W-1:0]       lend_reg, lend_next;
    hrlp_pkg::method_t      mfound_reg, mfound_next;
    hrlp_pkg::status_t      res;

    logic is_upper, is_digit;
    logic [VER_W-1:0] digit_val;

    function automatic logic [VER_W-1:0] add_digit(logic [VER_W-1:0] v,
                                                   logic [VER_W-1:0] d);
        logic [VER_W+3:0] r;
        r = {v, 3'b000} + {3'b000, v, 1'b0} + {4'b0000, d};
        return (r > {4'b0000, VerMax}) ? VerMax : r[VER_W-1:0];
    endfunction

    function automatic hrlp_pkg::method_t classify(logic [2:0] len, logic [31:0] b);
        hrlp_pkg::method_t m;
        m = hrlp_pkg::METHOD_UNKNOWN;
        if (len == 3'd3 && b == 32'h0047_4554)
            m = hrlp_pkg::METHOD_GET;
        else if (len == 3'd4 && b == 32'h4845_4144)
            m = hrlp_pkg::METHOD_HEAD;
        else if (len == 3'd4 && b == 32'h504F_5354)
            m = hrlp_pkg::METHOD_POST;
        return m;
    endfunction

    assign is_upper  = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
    assign is_digit  = (data_byte >= ChZero) && (data_byte <= ChNine);
    assign digit_val = VER_W'(data_byte - ChZero);

    always_comb
    begin
        state_next  = state_reg;
        mbytes_next = mbytes_reg;
        mlen_next   = mlen_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        start_next  = start_reg;
        mend_next   = mend_reg;
        ustart_next = ustart_reg;
        uend_next   = uend_reg;
        lend_next   = lend_reg;
        mfound_next = mfound_reg;
        pos_next    = pos_reg;
        res         = hrlp_pkg::STATUS_CONT;

        case (state_reg)
            ST_METHOD:
            begin
                if (data_byte == ChSp)
                begin
                    mend_next   = pos_reg;
                    mfound_next = classify(mlen_reg, mbytes_reg);
                    state_next  = ST_PRE_URI;
                end
                else if (is_upper)
                begin
                    if (mlen_reg < 3'd4)
                        mbytes_next = {mbytes_reg[23:0], data_byte};
                    if (mlen_reg != 3'd7)
                        mlen_next = mlen_reg + 3'd1;
                end
                else
                    res = hrlp_pkg::STATUS_BAD_METHOD;
            end
            ST_PRE_URI:
            begin
                if (data_byte == ChSlash)
                begin
                    ustart_next = pos_reg;
                    state_next  = ST_URI;
                end
                else if (data_byte != ChSp)
                    res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_URI:
            begin
                if (data_byte == ChSp)
                begin
                    uend_next  = pos_reg;
                    state_next = ST_PRE_PROTO;
                end
            end
            ST_PRE_PROTO:
            begin
                if (data_byte == ChH)
                    state_next = ST_H;
                else if (data_byte != ChSp)
                    res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_H:
            begin
                if (data_byte == ChT) state_next = ST_HT;
                else res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_HT:
            begin
                if (data_byte == ChT) state_next = ST_HTT;
                else res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_HTT:
            begin
                if (data_byte == ChP) state_next = ST_HTTP;
                else res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_HTTP:
            begin
                if (data_byte == ChSlash) state_next = ST_MAJ_FIRST;
                else res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_MAJ_FIRST:
            begin
                if (data_byte >= ChOne && data_byte <= ChNine)
                begin
                    major_next = digit_val;
                    state_next = ST_MAJ;
                end
                else
                    res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_MAJ:
            begin
                if (data_byte == ChDot)
                    state_next = ST_MIN_FIRST;
                else if (is_digit)
                    major_next = add_digit(major_reg, digit_val);
                else
                    res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_MIN_FIRST:
            begin
                if (is_digit)
                begin
                    minor_next = digit_val;
                    state_next = ST_MIN;
                end
                else
                    res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_MIN, ST_TRAIL:
            begin
                if (data_byte == ChCr)
                begin
                    lend_next  = pos_reg;
                    state_next = ST_CR;
                end
                else if (data_byte == ChLf)
                begin
                    lend_next = pos_reg;
                    res       = hrlp_pkg::STATUS_OK;
                end
                else if (data_byte == ChSp)
                    state_next = ST_TRAIL;
                else if (state_reg == ST_MIN && is_digit)
                    minor_next = add_digit(minor_reg, digit_val);
                else
                    res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            ST_CR:
            begin
                if (data_byte == ChLf) res = hrlp_pkg::STATUS_OK;
                else res = hrlp_pkg::STATUS_BAD_REQUEST;
            end
            default:
            begin
                start_next = pos_reg;
                if (data_byte != ChCr && data_byte != ChLf)
                begin
                    if (!is_upper)
                        res = hrlp_pkg::STATUS_BAD_METHOD;
                    else
                    begin
                        mbytes_next = {mbytes_reg[23:0], data_byte};
                        mlen_next   = mlen_reg + 3'd1;
                        state_next  = ST_METHOD;
                    end
                end
            end
        endcase

        // result fields come from the updated line record
        result = '0;
        result.status = res;
        if (res == hrlp_pkg::STATUS_OK)
        begin
            result.method_code       = mfound_next;
            result.version_major     = major_next;
            result.version_minor     = minor_next;
            result.line_start_offset = start_next;
            result.method_end_offset = mend_next;
            result.uri_start_offset  = ustart_next;
            result.uri_end_offset    = uend_next;
            result.line_end_offset   = lend_next;
        end

        // drop the line on completion or error
        if (res != hrlp_pkg::STATUS_CONT)
        begin
            state_next  = ST_START;
            mbytes_next = '0;
            mlen_next   = '0;
            major_next  = '0;
            minor_next  = '0;
            pos_next    = '0;
            start_next  = '0;
            mend_next   = '0;
            ustart_next = '0;
            uend_next   = '0;
            lend_next   = '0;
            mfound_next = hrlp_pkg::METHOD_UNKNOWN;
        end
        else if (pos_reg < PosLimit)
            pos_next = pos_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_START;
            mbytes_reg <= '0;
            mlen_reg   <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            mend_reg   <= '0;
            ustart_reg <= '0;
            uend_reg   <= '0;
            lend_reg   <= '0;
            mfound_reg <= hrlp_pkg::METHOD_UNKNOWN;
        end
        else if (step_en)
        begin
            state_reg  <= state_next;
            mbytes_reg <= mbytes_next;
            mlen_reg   <= mlen_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            mend_reg   <= mend_next;
            ustart_reg <= ustart_next;
            uend_reg   <= uend_next;
            lend_reg   <= lend_next;
            mfound_reg <= mfound_next;
        end
    end

endmodule

/* rtl/http_request_line_parser_unit.sv */
// An accepted input beat passes through the input register, the per-byte parse step and the result register.
// Throughput: one byte per cycle; the per-byte parse step sits between the input
// register and the result register, so a new byte is taken every cycle the
// result side keeps up.
// Reset (rst_n low, asynchronous): both registers empty, parser in its start state.
module http_request_line_parser_unit #(
    parameter int MAX_LINE = hrlp_pkg::DEFAULT_MAX_LINE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_ready,
    input  logic [7:0]                    data_byte,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [1:0]                    status,
    output logic [1:0]                    method_code,
    output logic [hrlp_pkg::VER_W-1:0]    version_major,
    output logic [hrlp_pkg::VER_W-1:0]    version_minor,
    output logic [hrlp_pkg::POS_W-1:0]    line_start_offset,
    output logic [hrlp_pkg::POS_W-1:0]    method_end_offset,
    output logic [hrlp_pkg::POS_W-1:0]    uri_start_offset,
    output logic [hrlp_pkg::POS_W-1:0]    uri_end_offset,
    output logic [hrlp_pkg::POS_W-1:0]    line_end_offset
);

    logic              in_full_reg;
    logic [7:0]        in_byte_reg;
    logic              out_full_reg;
    hrlp_pkg::result_t out_reg;
    hrlp_pkg::result_t step_result;
    logic              advance;

    // move the held byte forward when the result register is free or draining
    assign advance    = in_full_reg && (!out_full_reg || result_ready);
    assign byte_ready = !in_full_reg || advance;

    hrlp_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .data_byte (in_byte_reg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
                in_full_reg <= byte_valid;
            if (advance)
                out_full_reg <= 1'b1;
            else if (result_ready)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_byte_reg <= data_byte;
        if (advance)
            out_reg <= step_result;
    end

    assign result_valid      = out_full_reg;
    assign status            = out_reg.status;
    assign method_code       = out_reg.method_code;
    assign version_major     = out_reg.version_major;
    assign version_minor     = out_reg.version_minor;
    assign line_start_offset = out_reg.line_start_offset;
    assign method_end_offset = out_reg.method_end_offset;
    assign uri_start_offset  = out_reg.uri_start_offset;
    assign uri_end_offset    = out_reg.uri_end_offset;
    assign line_end_offset   = out_reg.line_end_offset;

endmodule
